// ===== design/jacobi_poisson_2d_solver_macros.svh =====
// ----------------------------------------------------------------------------
// Jacobi Poisson solver assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef JACOBI_POISSON_2D_SOLVER_MACROS_SVH
`define JACOBI_POISSON_2D_SOLVER_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define JPS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jps: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define JPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jps: next-cycle check failed");

`else

`define JPS_ASSERT_IMPL(label, ante, cons)
`define JPS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== design/jps_pkg.sv =====
// ----------------------------------------------------------------------------
// Jacobi Poisson solver package
// Shared widths, command and register codes, and the divider status type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jps_pkg;

  localparam int VALUE_BITS = 32;
  localparam int ACC_W      = 97;   // signed numerator, Q48.48
  localparam int MAG_W      = 96;   // numerator magnitude
  localparam int DVS_W      = 50;   // divisor width: (h1+h2) << 17
  localparam int DIM_W      = 7;
  localparam int CFG_IDX_W  = 3;

  localparam logic [1:0] CMD_LOAD_U = 2'd0;
  localparam logic [1:0] CMD_LOAD_F = 2'd1;
  localparam logic [1:0] CMD_RUN    = 2'd2;
  localparam logic [1:0] CMD_READ_U = 2'd3;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_H1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_H2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 3'd5;

  localparam logic [DIM_W-1:0] ROWS_RST  = 7'd64;
  localparam logic [DIM_W-1:0] COLS_RST  = 7'd64;
  localparam logic [31:0]      H_RST     = 32'd65536;
  localparam logic [31:0]      TOL_RST   = 32'd66;
  localparam logic [15:0]      LIMIT_RST = 16'd1000;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== design/jacobi_poisson_2d_solver.sv =====
// ----------------------------------------------------------------------------
// Jacobi Poisson solver, five-point stencil
// Grid store, sweep sequencer, shared multiplier, serial divider and root.
// ----------------------------------------------------------------------------
// Load commands leave the block ready at once for the next item; a read waits in
// ST_RD until the output register is free, and the input is not ready meanwhile.
// A run walks the grid: per sweep it copies rows*cols cells (one a cycle, then a
// tail state ST_COPY_TAIL), then for each interior cell accumulates the stencil terms
// through the shared multiplier and waits on the 96-step serial divider (skipped when
// both spacings are zero), and closes the sweep with a mean division and a square
// root. The input is not ready while a run is in progress. Result items wait in an
// output register.
`timescale 1ns / 1ps

`include "jacobi_poisson_2d_solver_macros.svh"

module jacobi_poisson_2d_solver #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // row[5:0], col[11:6], value[43:12], zero fill
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // cell_value[31:0], iterations_done[47:32],
                                  // final_error[79:48]
  output logic        out_tuser,  // kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [jps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_data
);

  import jps_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD, ST_HH, ST_HH2, ST_CHECK, ST_COPY, ST_COPY_TAIL,
    ST_T_ADDR, ST_T_MUL, ST_T_ACC, ST_DIV_GO, ST_DIV_WAIT, ST_SQ_PREP, ST_SQ_ADD,
    ST_MEAN_GO, ST_MEAN_WAIT, ST_SQRT, ST_REPORT
  } state_t;

  // configuration
  logic [DIM_W-1:0] rows_r, cols_r;
  logic [31:0]      h1_r, h2_r, tol_r;
  logic [15:0]      limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= ROWS_RST;
      cols_r  <= COLS_RST;
      h1_r    <= H_RST;
      h2_r    <= H_RST;
      tol_r   <= TOL_RST;
      limit_r <= LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ROWS:  rows_r  <= cfg_data[DIM_W-1:0];
        CFG_COLS:  cols_r  <= cfg_data[DIM_W-1:0];
        CFG_H1:    h1_r    <= cfg_data;
        CFG_H2:    h2_r    <= cfg_data;
        CFG_TOL:   tol_r   <= cfg_data;
        CFG_LIMIT: limit_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // input item
  logic [5:0]  in_row, in_col;
  logic [31:0] in_value;
  logic [1:0]  in_cmd;
  logic        in_acc, in_hit;
  logic [AW-1:0] in_addr;

  assign in_row   = in_tdata[5:0];
  assign in_col   = in_tdata[11:6];
  assign in_value = in_tdata[43:12];
  assign in_cmd   = in_tuser;
  assign in_acc   = in_tvalid && in_tready;
  assign in_hit   = (32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_COLS);
  assign in_addr  = AW'(32'(in_row) * MAX_COLS + 32'(in_col));

  // sequencer state
  state_t state_r;
  logic [DIM_W-1:0] n_r, m_r, i_r, j_r, ci_r, cj_r;
  logic [2:0]       t_r;
  logic             cp_valid_r, sgn_r, rd_hit_r;
  logic [AW-1:0]    cp_addr_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [63:0]      prod_r, hh_r, sum_r, sum_nxt, x_r, res_r, bit_r;
  logic [63:0]      x_nxt, res_nxt, sq_trial;
  logic [31:0]      old_r, nv_r;
  logic [15:0]      sweep_r;
  logic [35:0]      err_r, tol10;
  logic [4:0]       k_r;
  logic             out_valid_r, out_kind_r;
  logic [31:0]      out_cell_r, out_err_r;
  logic [15:0]      out_iter_r;
  logic             out_free;

  assign in_tready = (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_tready;

  // addresses
  logic [AW-1:0] idx, copy_addr, p_raddr;
  assign idx       = AW'(32'(i_r) * MAX_COLS + 32'(j_r));
  assign copy_addr = AW'(32'(ci_r) * MAX_COLS + 32'(cj_r));

  always_comb begin
    case (t_r)
      3'd2:    p_raddr = AW'(32'(i_r) * MAX_COLS + 32'(j_r) - 1);
      3'd3:    p_raddr = AW'(32'(i_r) * MAX_COLS + 32'(j_r) + 1);
      3'd4:    p_raddr = AW'(32'(i_r) * MAX_COLS + 32'(j_r) - MAX_COLS);
      3'd5:    p_raddr = AW'(32'(i_r) * MAX_COLS + 32'(j_r) + MAX_COLS);
      default: p_raddr = idx;
    endcase
  end

  // stores
  logic          u_we, u_re, p_we, f_we;
  logic [AW-1:0] u_waddr, u_raddr;
  logic [31:0]   u_wdata, u_rdata, p_rdata, f_rdata;

  assign u_we    = (in_acc && in_cmd == CMD_LOAD_U && in_hit) || (state_r == ST_SQ_PREP);
  assign u_waddr = (state_r == ST_IDLE) ? in_addr : idx;
  assign u_wdata = (state_r == ST_IDLE) ? in_value : nv_r;
  assign u_re    = (in_acc && in_cmd == CMD_READ_U) || (state_r == ST_COPY);
  assign u_raddr = (state_r == ST_IDLE) ? in_addr : copy_addr;
  assign p_we    = cp_valid_r && (state_r == ST_COPY || state_r == ST_COPY_TAIL);
  assign f_we    = in_acc && in_cmd == CMD_LOAD_F && in_hit;

  jps_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_grid_ram (
    .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
    .re(u_re), .raddr(u_raddr), .rdata(u_rdata)
  );

  jps_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_prev_ram (
    .clk(clk), .we(p_we), .waddr(cp_addr_r), .wdata(u_rdata),
    .re(state_r == ST_T_ADDR), .raddr(p_raddr), .rdata(p_rdata)
  );

  jps_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_src_ram (
    .clk(clk), .we(f_we), .waddr(in_addr), .wdata(in_value),
    .re(state_r == ST_T_ADDR), .raddr(idx), .rdata(f_rdata)
  );

  // shared multiplier, product registered
  logic [31:0] opd, opd_mag, coef, mul_a, mul_b;
  logic [32:0] diff, dm;

  assign opd     = (t_r <= 3'd1) ? f_rdata : p_rdata;
  assign opd_mag = opd[31] ? (~opd + 32'd1) : opd;
  assign diff    = {old_r[31], old_r} - {nv_r[31], nv_r};
  assign dm      = diff[32] ? (~diff + 33'd1) : diff;

  always_comb begin
    case (t_r)
      3'd0:         coef = hh_r[31:0];
      3'd1:         coef = hh_r[63:32];
      3'd2, 3'd3:   coef = h1_r;
      default:      coef = h2_r;
    endcase
    case (state_r)
      ST_HH:      begin mul_a = h1_r;     mul_b = h2_r;     end
      ST_T_MUL:   begin mul_a = coef;     mul_b = opd_mag;  end
      ST_SQ_PREP: begin mul_a = dm[31:0]; mul_b = dm[31:0]; end
      default:    begin mul_a = '0;       mul_b = '0;       end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // numerator accumulation
  logic [MAG_W-1:0] term, acc_mag;
  logic             acc_neg;

  always_comb begin
    case (t_r)
      3'd0:    term = {32'd0, prod_r};
      3'd1:    term = {prod_r, 32'd0};
      default: term = {16'd0, prod_r, 16'd0};
    endcase
    acc_nxt = sgn_r ? (acc_r - $signed({1'b0, term})) : (acc_r + $signed({1'b0, term}));
  end

  assign acc_neg = acc_r[ACC_W-1];
  assign acc_mag = MAG_W'(acc_neg ? -acc_r : acc_r);

  // divider, shared by the stencil and the mean
  logic [32:0]       hsum;
  logic [DVS_W-1:0]  dvsr;
  logic              dz, div_start;
  logic [MAG_W-1:0]  div_dvd, quot;
  logic [DVS_W-1:0]  div_dvs, rem;
  logic [13:0]       cells;
  div_stat_t         div_stat;

  assign hsum      = {1'b0, h1_r} + {1'b0, h2_r};
  assign dvsr      = {hsum, 17'd0};
  assign dz        = (hsum == 33'd0);
  assign cells     = {7'd0, n_r} * {7'd0, m_r};
  assign div_start = (state_r == ST_DIV_GO && !dz) || (state_r == ST_MEAN_GO);
  assign div_dvd   = (state_r == ST_MEAN_GO) ? {32'd0, sum_r} : acc_mag;
  assign div_dvs   = (state_r == ST_MEAN_GO) ? {36'd0, cells} : dvsr;

  jps_div #(.DW(MAG_W), .VW(DVS_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd), .divisor(div_dvs),
    .stat(div_stat), .quotient(quot), .remainder(rem)
  );

  // rounding and saturation of the new value
  logic [MAG_W:0] q1;
  logic           rnd, pos_ovf, neg_ovf;
  logic [31:0]    nv_div, nv_zero;

  assign rnd     = {rem, 1'b0} >= {1'b0, dvsr};
  assign q1      = {1'b0, quot} + {{MAG_W{1'b0}}, rnd};
  assign pos_ovf = |q1[MAG_W:31];
  assign neg_ovf = (|q1[MAG_W:32]) || (q1[31] && (|q1[30:0]));
  assign nv_div  = !acc_neg ? (pos_ovf ? 32'h7FFF_FFFF : q1[31:0])
                            : (neg_ovf ? 32'h8000_0000 : (~q1[31:0] + 32'd1));
  assign nv_zero = (acc_mag == '0) ? 32'd0 : (acc_neg ? 32'h8000_0000 : 32'h7FFF_FFFF);

  // squared-change sum, saturating
  logic [64:0] sum_add;
  assign sum_add = {1'b0, sum_r} + {1'b0, prod_r};
  assign sum_nxt = sum_add[64] ? {64{1'b1}} : sum_add[63:0];

  // one root step a cycle
  assign sq_trial = res_r + bit_r;
  assign x_nxt    = (x_r >= sq_trial) ? (x_r - sq_trial) : x_r;
  assign res_nxt  = (x_r >= sq_trial) ? ((res_r >> 1) + bit_r) : (res_r >> 1);

  assign tol10 = ({4'd0, tol_r} << 3) + ({4'd0, tol_r} << 1);

  logic j_more, i_more, copy_last;
  assign j_more    = ({1'b0, j_r} + 8'd2) < {1'b0, m_r};
  assign i_more    = ({1'b0, i_r} + 8'd2) < {1'b0, n_r};
  assign copy_last = ({1'b0, cj_r} + 8'd1 == {1'b0, m_r}) &&
                     ({1'b0, ci_r} + 8'd1 == {1'b0, n_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cp_valid_r  <= 1'b0;
    end else begin
      // the read and report states refill the output register themselves
      if (out_valid_r && out_tready && state_r != ST_RD && state_r != ST_REPORT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_cmd)
              CMD_RUN: begin
                if (rows_r < 7'd3)                n_r <= 7'd3;
                else if (32'(rows_r) > MAX_ROWS) n_r <= DIM_W'(MAX_ROWS);
                else                              n_r <= rows_r;
                if (cols_r < 7'd3)                m_r <= 7'd3;
                else if (32'(cols_r) > MAX_COLS) m_r <= DIM_W'(MAX_COLS);
                else                              m_r <= cols_r;
                sweep_r <= '0;
                err_r   <= tol10;
                state_r <= ST_HH;
              end
              CMD_READ_U: begin
                rd_hit_r <= in_hit;
                state_r  <= ST_RD;
              end
              default: ;
            endcase
          end
        end
        ST_RD: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_READ;
            out_cell_r  <= rd_hit_r ? u_rdata : 32'd0;
            out_iter_r  <= '0;
            out_err_r   <= '0;
            state_r     <= ST_IDLE;
          end
        end
        ST_HH:  state_r <= ST_HH2;
        ST_HH2: begin
          hh_r    <= prod_r;
          state_r <= ST_CHECK;
        end
        ST_CHECK: begin
          if (sweep_r < limit_r && err_r > {4'd0, tol_r}) begin
            sum_r      <= '0;
            ci_r       <= '0;
            cj_r       <= '0;
            cp_valid_r <= 1'b0;
            state_r    <= ST_COPY;
          end else begin
            state_r <= ST_REPORT;
          end
        end
        ST_COPY: begin
          cp_valid_r <= 1'b1;
          cp_addr_r  <= copy_addr;
          if (({1'b0, cj_r} + 8'd1) == {1'b0, m_r}) begin
            cj_r <= '0;
            ci_r <= ci_r + 1'b1;
          end else begin
            cj_r <= cj_r + 1'b1;
          end
          if (copy_last) state_r <= ST_COPY_TAIL;
        end
        ST_COPY_TAIL: begin
          cp_valid_r <= 1'b0;
          i_r        <= 7'd1;
          j_r        <= 7'd1;
          t_r        <= '0;
          acc_r      <= '0;
          state_r    <= ST_T_ADDR;
        end
        ST_T_ADDR: state_r <= ST_T_MUL;
        ST_T_MUL: begin
          if (t_r == 3'd6) begin
            old_r   <= p_rdata;
            state_r <= ST_DIV_GO;
          end else begin
            sgn_r   <= opd[31];
            state_r <= ST_T_ACC;
          end
        end
        ST_T_ACC: begin
          acc_r   <= acc_nxt;
          t_r     <= t_r + 1'b1;
          state_r <= ST_T_ADDR;
        end
        ST_DIV_GO: begin
          if (dz) begin
            nv_r    <= nv_zero;
            state_r <= ST_SQ_PREP;
          end else begin
            state_r <= ST_DIV_WAIT;
          end
        end
        ST_DIV_WAIT: begin
          if (div_stat.done) begin
            nv_r    <= nv_div;
            state_r <= ST_SQ_PREP;
          end
        end
        ST_SQ_PREP: state_r <= ST_SQ_ADD;
        ST_SQ_ADD: begin
          sum_r <= sum_nxt;
          t_r   <= '0;
          acc_r <= '0;
          if (j_more) begin
            j_r     <= j_r + 1'b1;
            state_r <= ST_T_ADDR;
          end else if (i_more) begin
            i_r     <= i_r + 1'b1;
            j_r     <= 7'd1;
            state_r <= ST_T_ADDR;
          end else begin
            state_r <= ST_MEAN_GO;
          end
        end
        ST_MEAN_GO: state_r <= ST_MEAN_WAIT;
        ST_MEAN_WAIT: begin
          if (div_stat.done) begin
            x_r     <= quot[63:0];
            res_r   <= '0;
            bit_r   <= 64'd1 << 62;
            k_r     <= '0;
            state_r <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          x_r   <= x_nxt;
          res_r <= res_nxt;
          bit_r <= bit_r >> 2;
          k_r   <= k_r + 1'b1;
          if (k_r == 5'd31) begin
            err_r   <= {4'd0, res_nxt[31:0]};
            sweep_r <= sweep_r + 1'b1;
            state_r <= ST_CHECK;
          end
        end
        ST_REPORT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_RUN;
            out_cell_r  <= '0;
            out_iter_r  <= sweep_r;
            out_err_r   <= (|err_r[35:32]) ? 32'hFFFF_FFFF : err_r[31:0];
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {out_err_r, out_iter_r, out_cell_r};

  `JPS_ASSERT_IMPL(a_div_start_idle, div_start, !div_stat.busy)
  `JPS_ASSERT_IMPL(a_stencil_interior, state_r == ST_T_ADDR,
                   (i_r >= 7'd1) && (j_r >= 7'd1) && (({1'b0, i_r} + 8'd2) <= {1'b0, n_r}) &&
                   (({1'b0, j_r} + 8'd2) <= {1'b0, m_r}))
  `JPS_ASSERT_IMPL(a_iter_bound, out_tvalid && (out_tuser == KIND_RUN),
                   out_tdata[47:32] <= limit_r)
  `JPS_ASSERT_NEXT(a_load_keeps_ready,
                   in_tvalid && in_tready && ((in_tuser == CMD_LOAD_U) || (in_tuser == CMD_LOAD_F)),
                   in_tready)

endmodule

// ===== design/jps_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/jps_div.sv =====
// ----------------------------------------------------------------------------
// Serial restoring divider
// One quotient bit per cycle, remainder kept.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jps_div #(
  parameter int DW = 96,
  parameter int VW = 50
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DW-1:0]       dividend,
  input  logic [VW-1:0]       divisor,
  output jps_pkg::div_stat_t  stat,
  output logic [DW-1:0]       quotient,
  output logic [VW-1:0]       remainder
);

  import jps_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic          busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] q_r, q_nxt;
  logic [VW-1:0] rem_r, rem_nxt, dvs_r;
  logic [VW:0]   trial;
  logic          ge;

  always_comb begin
    trial   = {rem_r, q_r[DW-1]};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? VW'(trial - {1'b0, dvs_r}) : VW'(trial);
    q_nxt   = {q_r[DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // done pulses for one cycle after the last quotient bit
      done_r <= !start && busy_r && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
        q_r    <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign stat      = '{busy: busy_r, done: done_r};
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule
